// File: hdl/cdf_sampling_engine_macros.svh
// Assertion macros used by the checker file of the sampling engine.
`ifndef CDF_SAMPLING_ENGINE_MACROS_SVH
`define CDF_SAMPLING_ENGINE_MACROS_SVH

// Checked on every clock edge outside reset.
`define CDF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CDF_ASSERT_RESET(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: hdl/cdf_pkg.sv
// Types and constants of the sampling engine.
package cdf_pkg;

   // Field widths of the words and of the table.
   localparam int SUM_W   = 42;
   localparam int DRAW_W  = 30;
   localparam int INDEX_W = 10;
   localparam int AMP_W   = 16;
   localparam int QC_W    = 4;
   localparam int SQ_W    = 32;

   // Action codes of a request word.
   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   // Qubit count after reset.
   localparam logic [QC_W-1:0] NUM_QUBITS_RESET = 4'd10;

   // Request word.
   typedef struct packed {
      logic                     action;
      logic                     first_amplitude;
      logic signed [AMP_W-1:0]  amp_real;
      logic signed [AMP_W-1:0]  amp_imag;
      logic [DRAW_W-1:0]        uniform_draw;
   } req_word_type;

   // Response word.
   typedef struct packed {
      logic [INDEX_W-1:0] sample_index;
      logic               out_of_range;
   } rsp_word_type;

   // Classified command passed from the front to the back.
   typedef struct packed {
      logic                     is_sample;
      logic                     zero_draw;
      logic                     first_amplitude;
      logic signed [AMP_W-1:0]  amp_real;
      logic signed [AMP_W-1:0]  amp_imag;
      logic [DRAW_W-1:0]        uniform_draw;
   } cmd_word_type;

endpackage

// File: hdl/cdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdf_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cdf_front.sv
// Front end: accepts request words, classifies them and queues them for the back end.
module cdf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cdf_pkg::req_word_type req_word,
   output logic                  cmd_valid,
   input  logic                  cmd_pop,
   output cdf_pkg::cmd_word_type cmd_word
);
   import cdf_pkg::*;

   localparam int QUEUE_DEPTH = 2;

   cmd_word_type queue_ff [QUEUE_DEPTH];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push;
   logic         pop;
   cmd_word_type classified;

   // The queue is full when both entries hold a word.
   assign req_stall = (count_ff == 2'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_pop && (count_ff != 2'd0);

   // Classify the incoming word.
   always_comb begin
      classified.is_sample       = (req_word.action == ACTION_SAMPLE);
      classified.zero_draw       = (req_word.uniform_draw == '0);
      classified.first_amplitude = req_word.first_amplitude;
      classified.amp_real        = req_word.amp_real;
      classified.amp_imag        = req_word.amp_imag;
      classified.uniform_draw    = req_word.uniform_draw;
   end

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; payload needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_word  = queue_ff[rd_ptr_ff];

endmodule

// File: hdl/cdf_back.sv
// Back end: accumulates loaded magnitudes into the table and runs the sample search.
module cdf_back #(
   parameter int MAX_QUBITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cdf_pkg::QC_W-1:0]          num_qubits,
   input  logic                              cmd_valid,
   output logic                              cmd_pop,
   input  cdf_pkg::cmd_word_type             cmd_word,
   output logic                              ram_wr_en,
   output logic [MAX_QUBITS-1:0]             ram_wr_addr,
   output logic [cdf_pkg::SUM_W-1:0]         ram_wr_data,
   output logic                              ram_rd_en,
   output logic [MAX_QUBITS-1:0]             ram_rd_addr,
   input  logic [cdf_pkg::SUM_W-1:0]         ram_rd_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output cdf_pkg::rsp_word_type             rsp_word
);
   import cdf_pkg::*;

   localparam int AW = MAX_QUBITS;
   localparam int CW = MAX_QUBITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_SEARCH,
      ST_RESULT
   } state_type;

   state_type         state_ff, state_in;
   logic [SQ_W-1:0]   sq_re_ff, sq_re_in;
   logic [SQ_W-1:0]   sq_im_ff, sq_im_in;
   logic              first_amp_ff, first_amp_in;
   logic [SUM_W-1:0]  running_sum_ff, running_sum_in;
   logic [CW-1:0]     load_pos_ff, load_pos_in;
   logic [DRAW_W-1:0] draw_ff, draw_in;
   logic [CW-1:0]     first_ff, first_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     step_ff, step_in;
   logic [CW-1:0]     res_idx_ff, res_idx_in;
   logic              res_oor_ff, res_oor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic [4:0]        qubits_eff;
   logic [CW-1:0]     dim;
   logic [CW-1:0]     dim_half;
   logic signed [SQ_W-1:0] re_ext;
   logic signed [SQ_W-1:0] im_ext;
   logic [SQ_W:0]     mag;
   logic [SUM_W-1:0]  base_sum;
   logic [CW-1:0]     base_pos;
   logic [SUM_W:0]    acc_sum;
   logic [SUM_W-1:0]  sat_sum;
   logic              probe_lt;
   logic [CW-1:0]     next_first;
   logic [CW-1:0]     next_count;
   logic [CW-1:0]     next_step;

   // Effective qubit count and vector size.
   always_comb begin
      if (num_qubits == '0) begin
         qubits_eff = 5'd1;
      end else if ({1'b0, num_qubits} > 5'(MAX_QUBITS)) begin
         qubits_eff = 5'(MAX_QUBITS);
      end else begin
         qubits_eff = {1'b0, num_qubits};
      end
   end

   assign dim      = CW'(1) << qubits_eff;
   assign dim_half = dim >> 1;

   // Sign-extended amplitudes for the squaring multipliers.
   assign re_ext = {{(SQ_W-AMP_W){cmd_word.amp_real[AMP_W-1]}}, cmd_word.amp_real};
   assign im_ext = {{(SQ_W-AMP_W){cmd_word.amp_imag[AMP_W-1]}}, cmd_word.amp_imag};

   // Saturating accumulation of the registered squared magnitude.
   assign mag      = {1'b0, sq_re_ff} + {1'b0, sq_im_ff};
   assign base_sum = first_amp_ff ? '0 : running_sum_ff;
   assign base_pos = first_amp_ff ? '0 : load_pos_ff;
   assign acc_sum  = {1'b0, base_sum} + {{(SUM_W-SQ_W){1'b0}}, mag};
   assign sat_sum  = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];

   // One lower-bound step on the table word read for the last probe.
   always_comb begin
      probe_lt = (ram_rd_data < {{(SUM_W-DRAW_W){1'b0}}, draw_ff});
      if (probe_lt) begin
         next_first = first_ff + step_ff + CW'(1);
         next_count = count_ff - step_ff - CW'(1);
      end else begin
         next_first = first_ff;
         next_count = step_ff;
      end
      next_step = next_count >> 1;
   end

   // Sequencer for loads and searches.
   always_comb begin
      state_in       = state_ff;
      sq_re_in       = sq_re_ff;
      sq_im_in       = sq_im_ff;
      first_amp_in   = first_amp_ff;
      running_sum_in = running_sum_ff;
      load_pos_in    = load_pos_ff;
      draw_in        = draw_ff;
      first_in       = first_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      res_idx_in     = res_idx_ff;
      res_oor_in     = res_oor_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_word_in    = rsp_word_ff;
      cmd_pop        = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = load_pos_ff[AW-1:0];
      ram_wr_data    = sat_sum;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = dim_half[AW-1:0];

      // The output register empties when its word is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd_word.is_sample) begin
                  draw_in = cmd_word.uniform_draw;
                  if (cmd_word.zero_draw) begin
                     res_idx_in = '0;
                     res_oor_in = 1'b1;
                     state_in   = ST_RESULT;
                  end else begin
                     // First probe at the middle of the active range.
                     first_in  = '0;
                     count_in  = dim;
                     step_in   = dim_half;
                     ram_rd_en = 1'b1;
                     state_in  = ST_SEARCH;
                  end
               end else begin
                  sq_re_in     = SQ_W'(re_ext * re_ext);
                  sq_im_in     = SQ_W'(im_ext * im_ext);
                  first_amp_in = cmd_word.first_amplitude;
                  state_in     = ST_ACCUM;
               end
            end
         end
         ST_ACCUM: begin
            // A load past the end of the vector leaves sum and table alone.
            running_sum_in = base_sum;
            load_pos_in    = base_pos;
            ram_wr_addr    = base_pos[AW-1:0];
            if (base_pos < dim) begin
               ram_wr_en      = 1'b1;
               running_sum_in = sat_sum;
               load_pos_in    = base_pos + CW'(1);
            end
            state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            first_in = next_first;
            count_in = next_count;
            step_in  = next_step;
            if (next_count == '0) begin
               // No entry at or above the draw means the draw exceeds the total.
               if (next_first == dim) begin
                  res_idx_in = '0;
                  res_oor_in = 1'b1;
               end else begin
                  res_idx_in = next_first;
                  res_oor_in = 1'b0;
               end
               state_in = ST_RESULT;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(next_first + next_step);
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_word_in.sample_index = INDEX_W'(res_idx_ff);
               rsp_word_in.out_of_range = res_oor_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         running_sum_ff <= '0;
         load_pos_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         running_sum_ff <= running_sum_in;
         load_pos_ff    <= load_pos_in;
         rsp_valid_ff   <= rsp_valid_in;
         sq_re_ff       <= sq_re_in;
         sq_im_ff       <= sq_im_in;
         first_amp_ff   <= first_amp_in;
         draw_ff        <= draw_in;
         first_ff       <= first_in;
         count_ff       <= count_in;
         step_ff        <= step_in;
         res_idx_ff     <= res_idx_in;
         res_oor_ff     <= res_oor_in;
         rsp_word_ff    <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: hdl/cdf_sampling_engine.sv
// Top level of the sampling engine: configuration register, front end, back end, table.
//
// Request words arrive on req_valid/req_stall/req_word. A load word carries one complex
// amplitude; its squared magnitude is added to a saturating running sum that is written
// into the cumulative table. A sample word carries a uniform draw; the engine answers
// with one response word on rsp_valid/rsp_stall/rsp_word holding the first table index
// whose cumulative value is at or above the draw, or index 0 with out_of_range set when
// the draw is zero or above the total. Loads produce no response.
// csr_write_enable/csr_write_data set the qubit count n; write it only while idle.
// A two-word queue sits between the front end and the back end. A load passes through the
// accumulate state before the back end takes its next word. A sample makes one table read
// per binary search step on the single read port of the table, from the issue in the idle
// state to the result state, which loads the response register; a zero draw goes straight
// from the idle state to the result state.
// Reset empties the queue and the output register, clears the running sum and the load
// position and sets n to 10; the table itself is not cleared. While rsp_stall is high the
// response word holds, the back end waits with its next result, and the queue keeps
// taking words until it is full.
module cdf_sampling_engine #(
   parameter int MAX_QUBITS = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  cdf_pkg::req_word_type       req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output cdf_pkg::rsp_word_type       rsp_word,
   input  logic                        csr_write_enable,
   input  logic [cdf_pkg::QC_W-1:0]    csr_write_data
);
   import cdf_pkg::*;

   logic [QC_W-1:0]       num_qubits_ff, num_qubits_in;
   logic                  cmd_valid;
   logic                  cmd_pop;
   cmd_word_type          cmd_word;
   logic                  ram_wr_en;
   logic [MAX_QUBITS-1:0] ram_wr_addr;
   logic [SUM_W-1:0]      ram_wr_data;
   logic                  ram_rd_en;
   logic [MAX_QUBITS-1:0] ram_rd_addr;
   logic [SUM_W-1:0]      ram_rd_data;

   // Qubit count register.
   assign num_qubits_in = csr_write_enable ? csr_write_data : num_qubits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_qubits_ff <= NUM_QUBITS_RESET;
      end else begin
         num_qubits_ff <= num_qubits_in;
      end
   end

   // Request intake and queue.
   cdf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_word  (cmd_word)
   );

   // Accumulation and search.
   cdf_back #(
      .MAX_QUBITS (MAX_QUBITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .num_qubits  (num_qubits_ff),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd_word    (cmd_word),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word)
   );

   // Cumulative probability table.
   cdf_ram #(
      .WIDTH (SUM_W),
      .DEPTH (2 ** MAX_QUBITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// File: hdl/cdf_sampling_engine_checker.sv
// Port-level assertions for the sampling engine and their bind to the top level.
`include "cdf_sampling_engine_macros.svh"

module cdf_sampling_engine_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_stall,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  cdf_pkg::rsp_word_type rsp_word
);
   import cdf_pkg::*;

   // A stalled response word stays in place.
   `CDF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word), "stalled response word changed")

   // An out-of-range response always reports index zero.
   `CDF_ASSERT(a_oor_index_zero, rsp_valid |-> !rsp_word.out_of_range || rsp_word.sample_index == '0, "out-of-range response has nonzero index")

   // Reset leaves no response pending.
   `CDF_ASSERT_RESET(a_reset_rsp_empty, reset |=> !rsp_valid, "response valid right after reset")

   // Reset leaves the request queue empty and open.
   `CDF_ASSERT_RESET(a_reset_req_open, reset |=> !req_stall, "request stalled right after reset")

endmodule

bind cdf_sampling_engine cdf_sampling_engine_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
